>>> rtl/core/ecd_pkg.sv
package ecd_pkg;

  localparam int unsigned DELTA_W  = 5;
  localparam int unsigned KEY_W    = 2;
  localparam int unsigned BRIGHT_W = 7;
  localparam int unsigned TEMP_W   = 13;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned STEP_W   = 9;

  localparam logic [TEMP_W-1:0]   TEMP_MIN    = 13'd2700;
  localparam logic [TEMP_W-1:0]   TEMP_MAX    = 13'd6500;
  localparam logic [TEMP_W-1:0]   TEMP_RESET  = 13'd5500;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX  = 7'd100;
  localparam logic [DUTY_W-1:0]   DUTY_FULL   = 10'd1000;
  localparam logic [STEP_W-1:0]   STEP_RESET  = 9'd50;
  localparam logic signed [DELTA_W-1:0] DELTA_LIMIT = 5'sd11;

  // 1000*(t-2700)/3800 reduces to 5*d/19
  localparam logic [15:0] RECIP_19  = 16'd55189;   // ceil(2^20/19)
  localparam int unsigned SHIFT_19  = 20;
  localparam logic [17:0] RECIP_100 = 18'd167773;  // ceil(2^24/100)
  localparam int unsigned SHIFT_100 = 24;

  typedef enum logic [KEY_W-1:0] {
    KEY_IDLE     = 2'd0,
    KEY_HELD     = 2'd1,
    KEY_RELEASED = 2'd2,
    KEY_UNUSED   = 2'd3
  } key_t;

  // one strobe per datapath step
  typedef struct packed {
    logic load;
    logic prod;
    logic update;
    logic div;
    logic divc;
    logic scale;
    logic recip;
    logic fin;
  } cmd_t;

endpackage

>>> rtl/core/encoder_cct_dimmer.sv
// Rotary-knob dimmer for a warm/cool tunable-white lamp.
// Input channel (in_valid/in_stall): one transaction per knob polling tick,
//   carrying the saturated encoder delta and the key state.
// Result channel (out_valid/out_stall): one transaction per input tick with
//   brightness, color temperature, power flag, the two PWM compare values
//   and the menu request flag.
// Config port (cfg_we/cfg_wdata): kelvin per accelerated detent. It is to be
//   written only while no tick is in flight; the block does not enforce this.
// The controller walks the datapath through its steps in order: multiply,
//   update, two reciprocal divides (by 19, then by 100 after brightness
//   scaling), and takes no new tick until the sequence is through.
// in_stall is low only while the controller idles. A finished result sits
//   in the output register, so the next tick can be taken while the
//   receiver stalls; that tick then waits in its last step until the
//   register frees up.
// Reset (synchronous, rst_n low): brightness 0, 5500 K, lamp off, no
//   pending press, step 50 K, both channels empty.
module encoder_cct_dimmer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ecd_pkg::DELTA_W-1:0]  in_encoder_delta,
  input  logic [ecd_pkg::KEY_W-1:0]           in_key_state,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ecd_pkg::BRIGHT_W-1:0]        out_brightness,
  output logic [ecd_pkg::TEMP_W-1:0]          out_color_temp,
  output logic                                out_power_on,
  output logic [ecd_pkg::DUTY_W-1:0]          out_warm_duty,
  output logic [ecd_pkg::DUTY_W-1:0]          out_cool_duty,
  output logic                                out_menu_request,
  input  logic                                cfg_we,
  input  logic [ecd_pkg::STEP_W-1:0]          cfg_wdata
);
  import ecd_pkg::*;

  // step strobes from the sequencer to the datapath
  cmd_t cmd;

  ecd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // holds lamp state, temp step and the result register
  ecd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_encoder_delta (in_encoder_delta),
    .in_key_state     (in_key_state),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_brightness   (out_brightness),
    .out_color_temp   (out_color_temp),
    .out_power_on     (out_power_on),
    .out_warm_duty    (out_warm_duty),
    .out_cool_duty    (out_cool_duty),
    .out_menu_request (out_menu_request)
  );

endmodule

>>> rtl/core/ecd_ctrl.sv
module ecd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output ecd_pkg::cmd_t cmd
);
  import ecd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PROD  = 8'b0000_0010,
    S_UPD   = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_DIVC  = 8'b0001_0000,
    S_SCALE = 8'b0010_0000,
    S_RECIP = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_accept;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.load   = in_accept;
    cmd.prod   = (state_r == S_PROD);
    cmd.update = (state_r == S_UPD);
    cmd.div    = (state_r == S_DIV);
    cmd.divc   = (state_r == S_DIVC);
    cmd.scale  = (state_r == S_SCALE);
    cmd.recip  = (state_r == S_RECIP);
    cmd.fin    = (state_r == S_FIN) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_PROD;
      S_PROD:  state_nxt = S_UPD;
      S_UPD:   state_nxt = S_DIV;
      S_DIV:   state_nxt = S_DIVC;
      S_DIVC:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_RECIP;
      S_RECIP: state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.fin) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_PROD))
    else $error("accepted transaction did not start the sequence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && out_stall) |=> (state_r == S_FIN))
    else $error("left final step while result still pending");

endmodule

>>> rtl/core/ecd_dp.sv
module ecd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ecd_pkg::cmd_t                       cmd,
  input  logic signed [ecd_pkg::DELTA_W-1:0]  in_encoder_delta,
  input  logic [ecd_pkg::KEY_W-1:0]           in_key_state,
  input  logic                                cfg_we,
  input  logic [ecd_pkg::STEP_W-1:0]          cfg_wdata,
  output logic [ecd_pkg::BRIGHT_W-1:0]        out_brightness,
  output logic [ecd_pkg::TEMP_W-1:0]          out_color_temp,
  output logic                                out_power_on,
  output logic [ecd_pkg::DUTY_W-1:0]          out_warm_duty,
  output logic [ecd_pkg::DUTY_W-1:0]          out_cool_duty,
  output logic                                out_menu_request
);
  import ecd_pkg::*;

  // architectural state
  logic [STEP_W-1:0]   step_r;
  logic [BRIGHT_W-1:0] bright_r, bright_nxt;
  logic [TEMP_W-1:0]   temp_r, temp_nxt;
  logic                lamp_r, lamp_nxt;
  logic                rot_r, rot_nxt;
  logic                menu_r, menu_nxt;

  // per-transaction working registers
  logic [KEY_W-1:0]   key_r;
  logic signed [7:0]  accel_r;
  logic signed [17:0] prod_r;
  logic [14:0]        x_r;
  logic [9:0]         q0_r;
  logic [9:0]         cool_base_r, warm_base_r;
  logic [16:0]        yw_r, yc_r;
  logic [9:0]         qw0_r, qc0_r;

  // result register
  logic [BRIGHT_W-1:0] o_bright_r;
  logic [TEMP_W-1:0]   o_temp_r;
  logic                o_power_r;
  logic [DUTY_W-1:0]   o_warm_r, o_cool_r;
  logic                o_menu_r;

  // accel = delta * |delta| after saturation
  logic signed [DELTA_W-1:0] delta_c;
  logic [3:0]                mag;
  logic signed [7:0]         accel_w;
  always_comb begin
    if (in_encoder_delta > DELTA_LIMIT) delta_c = DELTA_LIMIT;
    else if (in_encoder_delta < -DELTA_LIMIT) delta_c = -DELTA_LIMIT;
    else delta_c = in_encoder_delta;
    mag     = delta_c[DELTA_W-1] ? 4'(-delta_c) : delta_c[3:0];
    accel_w = 8'(8'(delta_c) * $signed({4'b0, mag}));
  end

  // kelvin change
  logic signed [17:0] prod_w;
  assign prod_w = 18'({{10{accel_r[7]}}, accel_r} * $signed({9'b0, step_r}));

  // state update
  logic signed [8:0]  bsum;
  logic signed [18:0] tsum;
  always_comb begin
    bright_nxt = bright_r;
    temp_nxt   = temp_r;
    rot_nxt    = rot_r;
    lamp_nxt   = lamp_r;
    menu_nxt   = 1'b0;
    bsum = $signed({2'b0, bright_r}) + $signed({accel_r[7], accel_r});
    tsum = $signed({6'b0, temp_r}) + $signed({prod_r[17], prod_r});
    case (key_t'(key_r))
      KEY_IDLE: begin
        if (bsum < 0) bright_nxt = '0;
        else if (bsum > $signed({2'b0, BRIGHT_MAX})) bright_nxt = BRIGHT_MAX;
        else bright_nxt = bsum[BRIGHT_W-1:0];
      end
      KEY_HELD: begin
        if (accel_r != 0) rot_nxt = 1'b1;
        if (tsum < $signed({6'b0, TEMP_MIN})) temp_nxt = TEMP_MIN;
        else if (tsum > $signed({6'b0, TEMP_MAX})) temp_nxt = TEMP_MAX;
        else temp_nxt = tsum[TEMP_W-1:0];
      end
      KEY_RELEASED: begin
        if (rot_r) rot_nxt = 1'b0;
        else menu_nxt = 1'b1;
      end
      default: ;
    endcase
    if (bright_nxt == 0) lamp_nxt = 1'b0;
    if (key_t'(key_r) == KEY_IDLE && accel_r != 0 && bright_nxt != 0) lamp_nxt = 1'b1;
  end

  // x = 5*(t-2700), q0 ~ x/19
  logic [11:0] d_w;
  logic [14:0] x_w;
  logic [30:0] xm_w;
  assign d_w  = 12'(temp_r - TEMP_MIN);
  assign x_w  = 15'({3'b0, d_w} + {1'b0, d_w, 2'b0});
  assign xm_w = 31'(x_w * RECIP_19);

  // correction and channel bases
  logic [14:0] r19_w, r19c_w;
  logic [9:0]  q_w;
  always_comb begin
    r19_w  = 15'(x_r - 15'(q0_r * 15'd19));
    q_w    = q0_r;
    r19c_w = r19_w;
    if (r19_w >= 15'd19) begin
      q_w    = 10'(q0_r + 10'd1);
      r19c_w = 15'(r19_w - 15'd19);
    end
  end

  // /100 by reciprocal
  logic [34:0] ywm_w, ycm_w;
  assign ywm_w = 35'(yw_r * RECIP_100);
  assign ycm_w = 35'(yc_r * RECIP_100);

  logic [16:0] rw_w, rc_w;
  logic [9:0]  qw_w, qc_w;
  always_comb begin
    rw_w = 17'(yw_r - 17'(qw0_r * 17'd100));
    rc_w = 17'(yc_r - 17'(qc0_r * 17'd100));
    qw_w = (rw_w >= 17'd100) ? 10'(qw0_r + 10'd1) : qw0_r;
    qc_w = (rc_w >= 17'd100) ? 10'(qc0_r + 10'd1) : qc0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RESET;
      bright_r <= '0;
      temp_r   <= TEMP_RESET;
      lamp_r   <= 1'b0;
      rot_r    <= 1'b0;
      menu_r   <= 1'b0;
    end else begin
      if (cfg_we) step_r <= cfg_wdata;
      if (cmd.update) begin
        bright_r <= bright_nxt;
        temp_r   <= temp_nxt;
        lamp_r   <= lamp_nxt;
        rot_r    <= rot_nxt;
        menu_r   <= menu_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= in_key_state;
      accel_r <= accel_w;
    end
    if (cmd.prod) prod_r <= prod_w;
    if (cmd.div) begin
      x_r  <= x_w;
      q0_r <= xm_w[SHIFT_19+9:SHIFT_19];
    end
    if (cmd.divc) begin
      cool_base_r <= q_w;
      warm_base_r <= 10'(DUTY_FULL - q_w - {9'b0, (r19c_w != 0)});
    end
    if (cmd.scale) begin
      yw_r <= 17'(warm_base_r * bright_r);
      yc_r <= 17'(cool_base_r * bright_r);
    end
    if (cmd.recip) begin
      qw0_r <= ywm_w[SHIFT_100+9:SHIFT_100];
      qc0_r <= ycm_w[SHIFT_100+9:SHIFT_100];
    end
    if (cmd.fin) begin
      o_bright_r <= bright_r;
      o_temp_r   <= temp_r;
      o_power_r  <= lamp_r;
      o_warm_r   <= lamp_r ? qw_w : '0;
      o_cool_r   <= lamp_r ? qc_w : '0;
      o_menu_r   <= menu_r;
    end
  end

  assign out_brightness   = o_bright_r;
  assign out_color_temp   = o_temp_r;
  assign out_power_on     = o_power_r;
  assign out_warm_duty    = o_warm_r;
  assign out_cool_duty    = o_cool_r;
  assign out_menu_request = o_menu_r;

endmodule
